FILE: rtl/gdr_pkg.sv
`timescale 1ns / 1ps
// gdr_pkg: shared types, sizes and arithmetic helpers for the gated delta rule step
// no dependencies

package gdr_pkg;

  localparam int HEAD_DIM    = 64;
  localparam int HEADS       = 8;
  localparam int SEQUENCES   = 4;
  localparam int DIM_W       = 6;
  localparam int HEAD_W      = 3;
  localparam int SEQ_W       = 2;
  localparam int ADDR_W      = SEQ_W + HEAD_W + 2 * DIM_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // one input request
  typedef struct packed {
    logic [1:0]         slice_index;
    logic [2:0]         head_index;
    logic signed [15:0] query_element;
    logic signed [15:0] key_element;
    logic signed [15:0] value_element;
    logic [16:0]        decay_gate;
    logic [16:0]        beta_gate;
    logic               last_element;
  } item_t;

  // one result request
  typedef struct packed {
    logic signed [31:0] output_value;
    logic [5:0]         output_index;
    logic               last_result;
    logic               error;
  } result_t;

  typedef enum logic [0:0] {
    REG_OUTPUT_SCALE     = 1'b0,
    REG_SEQUENCES_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERR,
    ST_DEC_RD,
    ST_DEC_MUL,
    ST_DEC_WR,
    ST_KD_RD,
    ST_KD_MUL,
    ST_KD_ACC,
    ST_DIFF,
    ST_B_LO,
    ST_B_HI,
    ST_B_ADD,
    ST_DLT_WR,
    ST_UP_RD,
    ST_UP_MUL,
    ST_UP_WR,
    ST_QD_RD,
    ST_QD_MUL,
    ST_QD_ACC,
    ST_QRND,
    ST_S_LO,
    ST_S_HI,
    ST_S_ADD,
    ST_OUT
  } seq_state_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // round half up then shift right arithmetically
  function automatic logic signed [63:0] round_shr(input logic signed [63:0] x,
                                                    input int unsigned s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

FILE: rtl/gdr_item_if.sv
`timescale 1ns / 1ps
// gdr_item_if, gdr_result_if: valid/ready channels for input and result requests
// depends on gdr_pkg

interface gdr_item_if import gdr_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface gdr_result_if import gdr_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

FILE: rtl/gated_delta_rule_step_top.sv
`timescale 1ns / 1ps
// gated_delta_rule_step_top: gated delta rule recurrence over a banked state memory
// depends on gdr_pkg and the channel interfaces in gdr_item_if.sv
//
//  channel   dir  handshake          payload
//  items     in   valid/ready        item_t (q, k, v element, gates, last mark)
//  results   out  valid/ready        result_t (Q16.16 value, column, last, error)
//  apb       in   psel/penable/pwrite  output_scale @0x0, sequences_in_use @0x4
//
// a non-last element is buffered and ready stays high; a refused request holds one error result
// a last element runs the state update on one shared 33x18 multiplier:
//   decay, key product, update and query product passes over every entry,
//   a beta step and a scale step per column; not ready again until done
// after reset a clearing pass zeroes the state memory and the input is not ready
// results stall the sequencer in place until taken

module gated_delta_rule_step_top import gdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gdr_item_if.sink    items,
  gdr_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  seq_state_t state, state_next;

  logic [15:0]       output_scale;
  logic [2:0]        sequences_in_use;
  logic [ADDR_W-1:0] clr, clr_next;
  logic [DIM_W-1:0]  pos, pos_next;
  logic [DIM_W-1:0]  r_idx, r_next;
  logic [DIM_W-1:0]  c_idx, c_next;
  logic [SEQ_W-1:0]  seq_r;
  logic [HEAD_W-1:0] head_r;
  logic [16:0]       decay_r;
  logic [16:0]       beta_r;

  logic signed [50:0] prod;
  logic signed [63:0] acc;
  logic signed [42:0] w;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  logic signed [31:0] s_rd;
  logic signed [15:0] q_rd;
  logic signed [15:0] k_rd;
  logic signed [15:0] v_rd;
  logic signed [31:0] d_rd;

  logic               accept;
  logic               err_item;
  logic               buf_we;
  logic               latch_head;
  logic               sm_we;
  logic               dm_we;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  sm_waddr;
  logic signed [31:0] sm_wdata;
  logic signed [63:0] prod_ext;
  logic signed [63:0] diff_sum;
  logic signed [63:0] qrnd_sum;

  logic signed [31:0] state_mem [STORE_DEPTH];
  logic signed [15:0] query_mem [HEAD_DIM];
  logic signed [15:0] key_mem [HEAD_DIM];
  logic signed [15:0] value_mem [HEAD_DIM];
  logic signed [31:0] delta_mem [HEAD_DIM];

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_scale     <= 16'd8192;
      sequences_in_use <= 3'd4;
    end else if (psel && penable && pwrite) begin
      case (reg_index_t'(paddr[2]))
        REG_OUTPUT_SCALE:     output_scale     <= pwdata[15:0];
        REG_SEQUENCES_IN_USE: sequences_in_use <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_OUTPUT_SCALE:     prdata = {16'd0, output_scale};
      REG_SEQUENCES_IN_USE: prdata = {29'd0, sequences_in_use};
      default:              prdata = '0;
    endcase
  end

  // request decode
  assign accept   = items.valid && items.ready;
  assign err_item = ({1'b0, items.payload.slice_index} >= sequences_in_use) &&
                    (sequences_in_use <= 3'(SEQUENCES));
  assign cur_addr = {seq_r, head_r, r_idx, c_idx};
  assign prod_ext = {{13{prod[50]}}, prod};
  assign diff_sum = ({{24{v_rd[15]}}, v_rd, 24'd0} - acc) + 64'sd2048;
  assign qrnd_sum = acc + 64'sd524288;

  // state memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (sm_we) state_mem[sm_waddr] <= sm_wdata;
    s_rd <= state_mem[cur_addr];
  end

  // element buffers
  always_ff @(posedge clk) begin
    if (buf_we) begin
      query_mem[pos] <= items.payload.query_element;
      key_mem[pos]   <= items.payload.key_element;
      value_mem[pos] <= items.payload.value_element;
    end
    q_rd <= query_mem[r_idx];
    k_rd <= key_mem[r_idx];
    v_rd <= value_mem[c_idx];
  end

  always_ff @(posedge clk) begin
    if (dm_we) delta_mem[c_idx] <= sat32(round_shr(acc, 16));
    d_rd <= delta_mem[c_idx];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DEC_MUL: begin
        mul_a = {s_rd[31], s_rd};
        mul_b = {1'b0, decay_r};
      end
      ST_KD_MUL: begin
        mul_a = {s_rd[31], s_rd};
        mul_b = {{2{k_rd[15]}}, k_rd};
      end
      ST_QD_MUL: begin
        mul_a = {s_rd[31], s_rd};
        mul_b = {{2{q_rd[15]}}, q_rd};
      end
      ST_UP_MUL: begin
        mul_a = {d_rd[31], d_rd};
        mul_b = {{2{k_rd[15]}}, k_rd};
      end
      ST_B_LO: begin
        mul_a = {12'd0, w[20:0]};
        mul_b = {1'b0, beta_r};
      end
      ST_B_HI: begin
        mul_a = {{11{w[42]}}, w[42:21]};
        mul_b = {1'b0, beta_r};
      end
      ST_S_LO: begin
        mul_a = {12'd0, w[20:0]};
        mul_b = {2'b00, output_scale};
      end
      ST_S_HI: begin
        mul_a = {{11{w[42]}}, w[42:21]};
        mul_b = {2'b00, output_scale};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      pos   <= '0;
      r_idx <= '0;
      c_idx <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      pos   <= pos_next;
      r_idx <= r_next;
      c_idx <= c_next;
    end
  end

  // head parameters taken with the last element
  always_ff @(posedge clk) begin
    if (latch_head) begin
      seq_r   <= items.payload.slice_index;
      head_r  <= items.payload.head_index;
      decay_r <= items.payload.decay_gate;
      beta_r  <= items.payload.beta_gate;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_DEC_MUL, ST_KD_MUL, ST_QD_MUL, ST_UP_MUL, ST_B_LO, ST_S_LO: prod <= mul_p;
      ST_B_HI, ST_S_HI: begin
        acc  <= prod_ext;
        prod <= mul_p;
      end
      ST_B_ADD, ST_S_ADD: acc <= acc + (prod_ext <<< 21);
      ST_KD_ACC, ST_QD_ACC: acc <= ((r_idx == '0) ? 64'sd0 : acc) + prod_ext;
      ST_DIFF: w <= diff_sum[54:12];
      ST_QRND: w <= qrnd_sum[62:20];
      default: ;
    endcase
  end

  // next state and control
  always_comb begin
    state_next = state;
    clr_next   = clr;
    pos_next   = pos;
    r_next     = r_idx;
    c_next     = c_idx;
    buf_we     = 1'b0;
    latch_head = 1'b0;
    sm_we      = 1'b0;
    sm_waddr   = cur_addr;
    sm_wdata   = '0;
    dm_we      = 1'b0;
    items.ready   = 1'b0;
    results.valid = 1'b0;
    results.payload = '0;
    case (state)
      ST_CLEAR: begin
        sm_we    = 1'b1;
        sm_waddr = clr;
        clr_next = clr + 1'b1;
        if (clr == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        items.ready = 1'b1;
        if (accept) begin
          if (err_item) begin
            state_next = ST_ERR;
          end else begin
            buf_we = 1'b1;
            if (items.payload.last_element) begin
              latch_head = 1'b1;
              pos_next   = '0;
              r_next     = '0;
              c_next     = '0;
              state_next = ST_DEC_RD;
            end else begin
              pos_next = pos + 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        results.valid = 1'b1;
        results.payload.last_result = 1'b1;
        results.payload.error       = 1'b1;
        if (results.ready) state_next = ST_IDLE;
      end
      // decay pass, row by row
      ST_DEC_RD:  state_next = ST_DEC_MUL;
      ST_DEC_MUL: state_next = ST_DEC_WR;
      ST_DEC_WR: begin
        sm_we    = 1'b1;
        sm_wdata = sat32(round_shr(prod_ext, 16));
        c_next   = c_idx + 1'b1;
        if (c_idx == DIM_W'(HEAD_DIM - 1)) begin
          r_next = r_idx + 1'b1;
          if (r_idx == DIM_W'(HEAD_DIM - 1)) begin
            r_next     = '0;
            c_next     = '0;
            state_next = ST_KD_RD;
          end else begin
            state_next = ST_DEC_RD;
          end
        end else begin
          state_next = ST_DEC_RD;
        end
      end
      // key product down each column
      ST_KD_RD:  state_next = ST_KD_MUL;
      ST_KD_MUL: state_next = ST_KD_ACC;
      ST_KD_ACC: begin
        if (r_idx == DIM_W'(HEAD_DIM - 1)) begin
          state_next = ST_DIFF;
        end else begin
          r_next     = r_idx + 1'b1;
          state_next = ST_KD_RD;
        end
      end
      ST_DIFF:  state_next = ST_B_LO;
      ST_B_LO:  state_next = ST_B_HI;
      ST_B_HI:  state_next = ST_B_ADD;
      ST_B_ADD: state_next = ST_DLT_WR;
      ST_DLT_WR: begin
        dm_we  = 1'b1;
        r_next = '0;
        c_next = c_idx + 1'b1;
        if (c_idx == DIM_W'(HEAD_DIM - 1)) begin
          c_next     = '0;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_KD_RD;
        end
      end
      // outer product update
      ST_UP_RD:  state_next = ST_UP_MUL;
      ST_UP_MUL: state_next = ST_UP_WR;
      ST_UP_WR: begin
        sm_we    = 1'b1;
        sm_wdata = sat32({{32{s_rd[31]}}, s_rd} + round_shr(prod_ext, 12));
        c_next   = c_idx + 1'b1;
        if (c_idx == DIM_W'(HEAD_DIM - 1)) begin
          r_next = r_idx + 1'b1;
          if (r_idx == DIM_W'(HEAD_DIM - 1)) begin
            r_next     = '0;
            c_next     = '0;
            state_next = ST_QD_RD;
          end else begin
            state_next = ST_UP_RD;
          end
        end else begin
          state_next = ST_UP_RD;
        end
      end
      // query product and scaled output per column
      ST_QD_RD:  state_next = ST_QD_MUL;
      ST_QD_MUL: state_next = ST_QD_ACC;
      ST_QD_ACC: begin
        if (r_idx == DIM_W'(HEAD_DIM - 1)) begin
          state_next = ST_QRND;
        end else begin
          r_next     = r_idx + 1'b1;
          state_next = ST_QD_RD;
        end
      end
      ST_QRND:  state_next = ST_S_LO;
      ST_S_LO:  state_next = ST_S_HI;
      ST_S_HI:  state_next = ST_S_ADD;
      ST_S_ADD: state_next = ST_OUT;
      ST_OUT: begin
        results.valid = 1'b1;
        results.payload.output_value = sat32(round_shr(acc, 16));
        results.payload.output_index = c_idx;
        results.payload.last_result  = (c_idx == DIM_W'(HEAD_DIM - 1));
        if (results.ready) begin
          r_next = '0;
          c_next = c_idx + 1'b1;
          if (c_idx == DIM_W'(HEAD_DIM - 1)) begin
            c_next     = '0;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_QD_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // checks
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.error |-> results.payload.last_result)
    else $error("error result without last mark");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("input taken while a result is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.payload.last_result |=> items.ready)
    else $error("not ready after final result");

endmodule
